>>> hw/rtl/quad_pid_motor_mixer_defines.svh
// assertion helpers for the motor mixer, clocked on clk and held off during reset
`ifndef QUAD_PID_MOTOR_MIXER_DEFINES_SVH
`define QUAD_PID_MOTOR_MIXER_DEFINES_SVH

// consequent checked in the same cycle
`define QPM_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent checked in the next cycle
`define QPM_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/qpm_pkg.sv
package qpm_pkg;

	localparam int unsigned ERR_W       = 16;
	localparam int unsigned THR_W       = 11;
	localparam int unsigned DT_W        = 16;
	localparam int unsigned GAIN_W      = 16;
	localparam int unsigned MOTOR_W     = 12;
	localparam int unsigned NUM_MOTORS  = 4;
	localparam int unsigned NUM_AXES    = 3;
	localparam int unsigned FRAC_BITS   = 16;
	localparam int unsigned INTEG_W     = 40;
	localparam int unsigned CORR_W      = 28;
	localparam int unsigned SUM_W       = 42;
	localparam int unsigned MIX_W       = 32;
	localparam int unsigned MUL_A_W     = 32;
	localparam int unsigned PROD_W      = MUL_A_W + DT_W;
	localparam int unsigned DIV_W       = 41;
	localparam int unsigned REM_W       = 5;
	localparam int unsigned DIG_W       = 16;
	localparam int unsigned NUM_DIG     = (DIV_W + DIG_W - 1) / DIG_W;
	localparam int unsigned RECIP_SH    = 26;
	localparam int unsigned RECIP_W     = 22;
	localparam int unsigned P_SHIFT     = 10;
	localparam int unsigned ID_SHIFT    = 8;
	localparam int unsigned DIV_P       = 25;
	localparam int unsigned DIV_ID      = 100;
	localparam int unsigned ID_PRE_SHIFT = $clog2(DIV_ID / DIV_P);
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned ITEM_W      = 3 * ERR_W + THR_W + DT_W;
	localparam int unsigned IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W = ((NUM_MOTORS * MOTOR_W + 7) / 8) * 8;

	localparam int unsigned IDLE_DRIVE    = 1024;
	localparam int unsigned MAX_DRIVE     = 2048;
	localparam int unsigned IDLE_THROTTLE = 100;

	localparam int unsigned CORRECTION_LIMIT_DEF = 600;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_YAW_GAIN_P  = 3'd0,
		REG_YAW_GAIN_I  = 3'd1,
		REG_YAW_GAIN_D  = 3'd2,
		REG_TILT_GAIN_P = 3'd3,
		REG_TILT_GAIN_I = 3'd4,
		REG_TILT_GAIN_D = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} gains_t;

	typedef struct packed {
		gains_t yaw;
		gains_t tilt;
	} gain_set_t;

	// yaw in the lowest bits, step_time in the highest
	typedef struct packed {
		logic [DT_W-1:0]  step_time;
		logic [THR_W-1:0] throttle;
		logic [ERR_W-1:0] roll_error;
		logic [ERR_W-1:0] pitch_error;
		logic [ERR_W-1:0] yaw_error;
	} item_t;

	typedef struct packed {
		logic             start;
		logic             by_100;
		logic [DIV_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic                             valid;
		logic [NUM_MOTORS-1:0][MOTOR_W-1:0] motors;
	} core_rsp_t;

endpackage

>>> hw/rtl/quad_pid_motor_mixer.sv
// Three-axis PID controller with X-frame motor mixer. Each request carries the yaw, pitch and
// roll errors (Q11.4 degrees), a throttle and the loop time (2^-20 s units); it returns four
// motor drives in 1024..2048, all at 1024 while throttle is below 100. Yaw uses the yaw gains,
// pitch and roll share the tilt gains (gains in hundredths); each axis keeps a saturating
// 40-bit integral and its previous error, and each PID sum is clamped to +-CORRECTION_LIMIT.
// The sequencer runs nine terms (P, I and D on three axes); each takes one (P) or two (I, D)
// passes through one shared 32x16 multiplier, a start state and then a divide-by-25 unit that
// handles 16 dividend bits per cycle with a reciprocal multiply; each axis is then summed and
// clamped, the four motors are mixed one per cycle, and a done state hands the result over.
// s_axis_tready is high only while the sequencer is idle, so a request is taken only once the
// previous one has been through the sequencer; a finished result waits in the output register,
// so the next request can be taken while the previous result is still pending, and a second
// finished result holds the sequencer until the first one is accepted.
// Gain registers are written through cfg_we/cfg_index/cfg_data and should change only when idle.

`include "quad_pid_motor_mixer_defines.svh"

module quad_pid_motor_mixer #(
	parameter int unsigned CORRECTION_LIMIT = qpm_pkg::CORRECTION_LIMIT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// yaw_error[15:0], pitch_error[31:16], roll_error[47:32], throttle[58:48],
	// step_time[74:59], zero pad to 80
	input  logic [qpm_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// motor_front_a[11:0], motor_front_b[23:12], motor_rear_a[35:24], motor_rear_b[47:36]
	output logic [qpm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	input  logic                                  cfg_we,
	input  logic [qpm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [qpm_pkg::GAIN_W-1:0]            cfg_data
);

	localparam int unsigned MOTOR_W = qpm_pkg::MOTOR_W;
	localparam int unsigned NUM_MOT = qpm_pkg::NUM_MOTORS;

	qpm_pkg::gain_set_t gains_q;
	qpm_pkg::item_t     item;
	qpm_pkg::core_rsp_t core_rsp;

	logic                            core_idle;
	logic                            push_ok;
	logic                            out_valid_q;
	logic [NUM_MOT-1:0][MOTOR_W-1:0] out_q;
	logic                            drive_in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				qpm_pkg::REG_YAW_GAIN_P:  gains_q.yaw.kp  <= cfg_data;
				qpm_pkg::REG_YAW_GAIN_I:  gains_q.yaw.ki  <= cfg_data;
				qpm_pkg::REG_YAW_GAIN_D:  gains_q.yaw.kd  <= cfg_data;
				qpm_pkg::REG_TILT_GAIN_P: gains_q.tilt.kp <= cfg_data;
				qpm_pkg::REG_TILT_GAIN_I: gains_q.tilt.ki <= cfg_data;
				qpm_pkg::REG_TILT_GAIN_D: gains_q.tilt.kd <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign item          = qpm_pkg::item_t'(s_axis_tdata[qpm_pkg::ITEM_W-1:0]);
	assign s_axis_tready = core_idle;
	assign push_ok       = !out_valid_q || m_axis_tready;

	qpm_core #(
		.CORRECTION_LIMIT (CORRECTION_LIMIT)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (s_axis_tvalid && s_axis_tready),
		.item    (item),
		.gains   (gains_q),
		.push_ok (push_ok),
		.idle    (core_idle),
		.rsp     (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_rsp.valid && push_ok) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_rsp.valid && push_ok) begin
			out_q <= core_rsp.motors;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = qpm_pkg::OUT_TDATA_W'(out_q);

	always_comb begin
		drive_in_range = 1'b1;
		for (int i = 0; i < NUM_MOT; i++) begin
			if (out_q[i] < MOTOR_W'(qpm_pkg::IDLE_DRIVE) ||
			    out_q[i] > MOTOR_W'(qpm_pkg::MAX_DRIVE)) begin
				drive_in_range = 1'b0;
			end
		end
	end

	`QPM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"request accepted but sequencer still ready")
	`QPM_ASSERT_NOW(a_drive_in_range, m_axis_tvalid, drive_in_range,
		"motor drive outside idle to max range")
	`QPM_ASSERT_NOW(a_result_after_work, $rose(m_axis_tvalid), $past(!s_axis_tready),
		"result appeared without sequencer work")

endmodule

>>> hw/rtl/qpm_div.sv
module qpm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  qpm_pkg::div_req_t  req,
	output qpm_pkg::div_rsp_t  rsp
);

	localparam int unsigned DIV_W    = qpm_pkg::DIV_W;
	localparam int unsigned REM_W    = qpm_pkg::REM_W;
	localparam int unsigned DIG_W    = qpm_pkg::DIG_W;
	localparam int unsigned NUM_DIG  = qpm_pkg::NUM_DIG;
	localparam int unsigned SPAN_W   = DIG_W * NUM_DIG;
	localparam int unsigned PART_W   = REM_W + DIG_W;
	localparam int unsigned RECIP_SH = qpm_pkg::RECIP_SH;
	localparam int unsigned RECIP_W  = qpm_pkg::RECIP_W;
	localparam int unsigned RPROD_W  = PART_W + RECIP_W;
	localparam int unsigned CNT_W    = $clog2(NUM_DIG + 1);

	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((2 ** RECIP_SH) + qpm_pkg::DIV_P - 1) / qpm_pkg::DIV_P);
	localparam logic [REM_W-1:0] DIVISOR = REM_W'(qpm_pkg::DIV_P);

	logic [SPAN_W-1:0] num_q;
	logic [SPAN_W-1:0] quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [PART_W-1:0]  part;
	logic [RPROD_W-1:0] rprod;
	logic [DIG_W-1:0]   q_dig;
	logic [REM_W-1:0]   rem_nx;

	// long division by 25, one 16-bit digit per cycle; the digit quotient comes from a
	// reciprocal multiply, exact because the partial dividend stays below 25 * 2^16
	always_comb begin
		part   = {rem_q, num_q[SPAN_W-1 -: DIG_W]};
		rprod  = RPROD_W'(part) * RPROD_W'(RECIP);
		q_dig  = rprod[RECIP_SH +: DIG_W];
		// remainder is below 32, so the low bits are enough
		rem_nx = part[REM_W-1:0] - REM_W'(q_dig[REM_W-1:0] * DIVISOR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_DIG);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// divide by 100 is a pre-shift by two followed by divide by 25
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.by_100 ? SPAN_W'(req.dividend >> qpm_pkg::ID_PRE_SHIFT) :
				SPAN_W'(req.dividend);
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			num_q <= {num_q[SPAN_W-DIG_W-1:0], {DIG_W{1'b0}}};
			quo_q <= {quo_q[SPAN_W-DIG_W-1:0], q_dig};
			rem_q <= rem_nx;
		end
	end

	assign rsp.done     = busy_q && (cnt_q == '0);
	assign rsp.quotient = quo_q[DIV_W-1:0];

endmodule

>>> hw/rtl/qpm_core.sv
module qpm_core #(
	parameter int unsigned CORRECTION_LIMIT = qpm_pkg::CORRECTION_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  qpm_pkg::item_t      item,
	input  qpm_pkg::gain_set_t  gains,
	input  logic                push_ok,
	output logic                idle,
	output qpm_pkg::core_rsp_t  rsp
);

	localparam int unsigned ERR_W     = qpm_pkg::ERR_W;
	localparam int unsigned THR_W     = qpm_pkg::THR_W;
	localparam int unsigned DT_W      = qpm_pkg::DT_W;
	localparam int unsigned GAIN_W    = qpm_pkg::GAIN_W;
	localparam int unsigned MOTOR_W   = qpm_pkg::MOTOR_W;
	localparam int unsigned NUM_MOT   = qpm_pkg::NUM_MOTORS;
	localparam int unsigned NUM_AXES  = qpm_pkg::NUM_AXES;
	localparam int unsigned FRAC_BITS = qpm_pkg::FRAC_BITS;
	localparam int unsigned INTEG_W   = qpm_pkg::INTEG_W;
	localparam int unsigned CORR_W    = qpm_pkg::CORR_W;
	localparam int unsigned SUM_W     = qpm_pkg::SUM_W;
	localparam int unsigned MIX_W     = qpm_pkg::MIX_W;
	localparam int unsigned MUL_A_W   = qpm_pkg::MUL_A_W;
	localparam int unsigned PROD_W    = qpm_pkg::PROD_W;
	localparam int unsigned DIV_W     = qpm_pkg::DIV_W;
	localparam int unsigned P_SHIFT   = qpm_pkg::P_SHIFT;
	localparam int unsigned ID_SHIFT  = qpm_pkg::ID_SHIFT;
	localparam int unsigned AXIS_W    = $clog2(NUM_AXES);
	localparam int unsigned MOT_IDX_W = $clog2(NUM_MOT);

	localparam logic [AXIS_W-1:0] AXIS_YAW   = AXIS_W'(0);
	localparam logic [AXIS_W-1:0] AXIS_PITCH = AXIS_W'(1);
	localparam logic [AXIS_W-1:0] AXIS_ROLL  = AXIS_W'(2);

	localparam logic signed [SUM_W-1:0] LIM     = SUM_W'(CORRECTION_LIMIT * (2 ** FRAC_BITS));
	localparam logic signed [SUM_W-1:0] NEG_LIM = -LIM;
	localparam logic signed [SUM_W-1:0] INT_HI  = (SUM_W'(1) <<< (INTEG_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] INT_LO  = -(SUM_W'(1) <<< (INTEG_W - 1));
	localparam logic signed [MIX_W-1:0] DRV_LO  =
		MIX_W'(qpm_pkg::IDLE_DRIVE * (2 ** FRAC_BITS));

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_MUL_A    = 8'b0000_0010,
		ST_MUL_B    = 8'b0000_0100,
		ST_DIV_GO   = 8'b0000_1000,
		ST_DIV_WAIT = 8'b0001_0000,
		ST_ACCUM    = 8'b0010_0000,
		ST_MIX      = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		TERM_P = 2'd0,
		TERM_I = 2'd1,
		TERM_D = 2'd2
	} term_t;

	state_t                   state_q;
	term_t                    term_q;
	logic [AXIS_W-1:0]        axis_q;
	logic [MOT_IDX_W-1:0]     motor_q;
	logic signed [ERR_W-1:0]  err_q   [NUM_AXES];
	logic signed [ERR_W-1:0]  prior_q [NUM_AXES];
	logic signed [INTEG_W-1:0] integ_q [NUM_AXES];
	logic signed [CORR_W-1:0] corr_q  [NUM_AXES];
	logic [THR_W-1:0]         thr_q;
	logic [DT_W-1:0]          dt_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     neg_q;
	logic signed [SUM_W-1:0]  p_q;
	logic signed [SUM_W-1:0]  d_q;
	logic [NUM_MOT-1:0][MOTOR_W-1:0] drive_q;

	qpm_pkg::div_req_t div_req;
	qpm_pkg::div_rsp_t div_rsp;
	qpm_pkg::gains_t   g;

	logic signed [ERR_W-1:0]   cur_err;
	logic signed [ERR_W:0]     diff;
	logic [ERR_W-1:0]          err_mag;
	logic [ERR_W-1:0]          diff_mag;
	logic                      term_neg;
	logic [MUL_A_W-1:0]        mul_a;
	logic [DT_W-1:0]           mul_b;
	logic [PROD_W-1:0]         mul_p;
	logic signed [SUM_W-1:0]   q_ext;
	logic signed [SUM_W-1:0]   term_val;
	logic signed [SUM_W-1:0]   integ_ext;
	logic signed [SUM_W-1:0]   integ_sum;
	logic signed [SUM_W-1:0]   integ_sat;
	logic signed [SUM_W-1:0]   pid_sum;
	logic signed [SUM_W-1:0]   pid_clamp;
	logic signed [MIX_W-1:0]   base_s;
	logic signed [MIX_W-1:0]   cp_x;
	logic signed [MIX_W-1:0]   cr_x;
	logic signed [MIX_W-1:0]   cy_x;
	logic signed [MIX_W-1:0]   tot_s;
	logic [MIX_W-FRAC_BITS-1:0] whole;
	logic [MOTOR_W-1:0]        drive_nx;

	// operand selection for the shared multiplier
	always_comb begin
		g        = (axis_q == AXIS_YAW) ? gains.yaw : gains.tilt;
		cur_err  = err_q[axis_q];
		diff     = {cur_err[ERR_W-1], cur_err} - {prior_q[axis_q][ERR_W-1], prior_q[axis_q]};
		err_mag  = cur_err[ERR_W-1] ? ERR_W'(-cur_err) : ERR_W'(cur_err);
		diff_mag = diff[ERR_W] ? ERR_W'(-diff) : ERR_W'(diff);
		term_neg = (term_q == TERM_D) ? diff[ERR_W] : cur_err[ERR_W-1];
		if (state_q == ST_MUL_B) begin
			mul_a = prod_q[MUL_A_W-1:0];
			mul_b = dt_q;
		end else begin
			mul_a = MUL_A_W'((term_q == TERM_D) ? diff_mag : err_mag);
			case (term_q)
				TERM_P:  mul_b = DT_W'(g.kp);
				TERM_I:  mul_b = DT_W'(g.ki);
				TERM_D:  mul_b = DT_W'(g.kd);
				default: mul_b = '0;
			endcase
		end
		mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// p: |e|*kp*1024/25, i and d: |x|*k*dt/256/100 with the I or D gain k, all truncated toward zero
	always_comb begin
		div_req.start    = (state_q == ST_DIV_GO);
		div_req.by_100   = (term_q != TERM_P);
		div_req.dividend = (term_q == TERM_P) ?
			{prod_q[DIV_W-P_SHIFT-1:0], {P_SHIFT{1'b0}}} :
			DIV_W'(prod_q[PROD_W-1:ID_SHIFT]);
	end

	qpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		q_ext     = $signed({{(SUM_W-DIV_W){1'b0}}, div_rsp.quotient});
		term_val  = neg_q ? -q_ext : q_ext;
		integ_ext = {{(SUM_W-INTEG_W){integ_q[axis_q][INTEG_W-1]}}, integ_q[axis_q]};
		integ_sum = integ_ext + term_val;
		if (integ_sum > INT_HI) begin
			integ_sat = INT_HI;
		end else if (integ_sum < INT_LO) begin
			integ_sat = INT_LO;
		end else begin
			integ_sat = integ_sum;
		end
		pid_sum = p_q + integ_ext + d_q;
		if (pid_sum > LIM) begin
			pid_clamp = LIM;
		end else if (pid_sum < NEG_LIM) begin
			pid_clamp = NEG_LIM;
		end else begin
			pid_clamp = pid_sum;
		end
	end

	// mixer: pitch adds on motors 0,1, roll on 0,3, yaw on 0,2
	always_comb begin
		base_s = $signed(MIX_W'(qpm_pkg::IDLE_DRIVE + thr_q) << FRAC_BITS);
		cp_x   = {{(MIX_W-CORR_W){corr_q[AXIS_PITCH][CORR_W-1]}}, corr_q[AXIS_PITCH]};
		cr_x   = {{(MIX_W-CORR_W){corr_q[AXIS_ROLL][CORR_W-1]}}, corr_q[AXIS_ROLL]};
		cy_x   = {{(MIX_W-CORR_W){corr_q[AXIS_YAW][CORR_W-1]}}, corr_q[AXIS_YAW]};
		tot_s  = base_s
			+ (!motor_q[1] ? cp_x : -cp_x)
			+ (!(motor_q[1] ^ motor_q[0]) ? cr_x : -cr_x)
			+ (!motor_q[0] ? cy_x : -cy_x);
		whole  = tot_s[MIX_W-1:FRAC_BITS];
		if (thr_q < THR_W'(qpm_pkg::IDLE_THROTTLE) || tot_s < DRV_LO) begin
			drive_nx = MOTOR_W'(qpm_pkg::IDLE_DRIVE);
		end else if (whole > (MIX_W-FRAC_BITS)'(qpm_pkg::MAX_DRIVE)) begin
			drive_nx = MOTOR_W'(qpm_pkg::MAX_DRIVE);
		end else begin
			drive_nx = whole[MOTOR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			term_q  <= TERM_P;
			axis_q  <= AXIS_YAW;
			motor_q <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				integ_q[i] <= '0;
				prior_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL_A;
						term_q  <= TERM_P;
						axis_q  <= AXIS_YAW;
					end
				end
				ST_MUL_A: begin
					state_q <= (term_q == TERM_P) ? ST_DIV_GO : ST_MUL_B;
				end
				ST_MUL_B: begin
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						case (term_q)
							TERM_P: begin
								term_q  <= TERM_I;
								state_q <= ST_MUL_A;
							end
							TERM_I: begin
								integ_q[axis_q] <= integ_sat[INTEG_W-1:0];
								term_q          <= TERM_D;
								state_q         <= ST_MUL_A;
							end
							default: begin
								state_q <= ST_ACCUM;
							end
						endcase
					end
				end
				ST_ACCUM: begin
					prior_q[axis_q] <= cur_err;
					term_q          <= TERM_P;
					if (axis_q == AXIS_ROLL) begin
						axis_q  <= AXIS_YAW;
						motor_q <= '0;
						state_q <= ST_MIX;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_MUL_A;
					end
				end
				ST_MIX: begin
					motor_q <= motor_q + 1'b1;
					if (motor_q == MOT_IDX_W'(NUM_MOT - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (push_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			err_q[AXIS_YAW]   <= item.yaw_error;
			err_q[AXIS_PITCH] <= item.pitch_error;
			err_q[AXIS_ROLL]  <= item.roll_error;
			thr_q             <= item.throttle;
			dt_q              <= item.step_time;
		end
		if (state_q == ST_MUL_A || state_q == ST_MUL_B) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_MUL_A) begin
			neg_q <= term_neg;
		end
		if (state_q == ST_DIV_WAIT && div_rsp.done) begin
			if (term_q == TERM_P) begin
				p_q <= term_val;
			end
			if (term_q == TERM_D) begin
				d_q <= term_val;
			end
		end
		if (state_q == ST_ACCUM) begin
			corr_q[axis_q] <= pid_clamp[CORR_W-1:0];
		end
		if (state_q == ST_MIX) begin
			drive_q[motor_q] <= drive_nx;
		end
	end

	assign idle        = (state_q == ST_IDLE);
	assign rsp.valid   = (state_q == ST_DONE);
	assign rsp.motors  = drive_q;

endmodule

>>> test/quad_pid_motor_mixer_tb.sv
module quad_pid_motor_mixer_tb;
	import qpm_pkg::*;

	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int DRAIN_CYCLES = 450;
	localparam int MAX_REPORTS = 200;
	localparam int AXIS_YAW = 0;
	localparam int AXIS_PITCH = 1;
	localparam int AXIS_ROLL = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam longint FIX_ONE = longint'(1) << FRAC_BITS;
	localparam longint CORR_LIMIT = longint'(CORRECTION_LIMIT_DEF) * FIX_ONE;
	localparam longint INTEG_MAX = (longint'(1) << (INTEG_W - 1)) - 1;
	localparam longint INTEG_MIN = -INTEG_MAX - 1;

	typedef logic [NUM_MOTORS-1:0][MOTOR_W-1:0] drives_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// yaw_error, pitch_error, roll_error, throttle, step_time, zero pad
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// motor_front_a, motor_front_b, motor_rear_a, motor_rear_b
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0] cfg_data;

	gain_set_t gain_model = '0;
	logic signed [INTEG_W-1:0] axis_integral [NUM_AXES] = '{default: '0};
	logic signed [ERR_W-1:0] axis_prior [NUM_AXES] = '{default: '0};
	drives_t pending_drives [$];
	string motor_name [NUM_MOTORS] = '{"motor_front_a", "motor_front_b", "motor_rear_a",
		"motor_rear_b"};

	int mismatch_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int stall_hold = 0;

	always #1 clk = ~clk;

	quad_pid_motor_mixer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// one axis: all terms in 2^-16 units of correction, quotients truncated toward zero
	function automatic longint pid_axis_step(input int axis, input longint err, input longint kp,
		input longint ki, input longint kd, input longint dt);
		longint p_term, integ, d_term, total;
		p_term = err * kp * 1024 / 25;
		integ = longint'(axis_integral[axis]) + err * ki * dt / 25600;
		if (integ > INTEG_MAX) integ = INTEG_MAX;
		if (integ < INTEG_MIN) integ = INTEG_MIN;
		axis_integral[axis] = integ[INTEG_W-1:0];
		d_term = kd * (err - longint'(axis_prior[axis])) * dt / 25600;
		axis_prior[axis] = err[ERR_W-1:0];
		total = p_term + integ + d_term;
		if (total > CORR_LIMIT) total = CORR_LIMIT;
		if (total < -CORR_LIMIT) total = -CORR_LIMIT;
		return total;
	endfunction

	function automatic logic [MOTOR_W-1:0] drive_level(input longint total);
		longint level;
		if (total < longint'(IDLE_DRIVE) * FIX_ONE) return MOTOR_W'(IDLE_DRIVE);
		level = total >>> FRAC_BITS;
		if (level > longint'(MAX_DRIVE)) level = longint'(MAX_DRIVE);
		return level[MOTOR_W-1:0];
	endfunction

	function automatic drives_t predict_drives(input item_t it);
		longint yaw_corr, pitch_corr, roll_corr, base;
		drives_t drives;
		yaw_corr = pid_axis_step(AXIS_YAW, longint'($signed(it.yaw_error)),
			longint'(gain_model.yaw.kp), longint'(gain_model.yaw.ki),
			longint'(gain_model.yaw.kd), longint'(it.step_time));
		pitch_corr = pid_axis_step(AXIS_PITCH, longint'($signed(it.pitch_error)),
			longint'(gain_model.tilt.kp), longint'(gain_model.tilt.ki),
			longint'(gain_model.tilt.kd), longint'(it.step_time));
		roll_corr = pid_axis_step(AXIS_ROLL, longint'($signed(it.roll_error)),
			longint'(gain_model.tilt.kp), longint'(gain_model.tilt.ki),
			longint'(gain_model.tilt.kd), longint'(it.step_time));
		// the pids still run and keep their state while the motors idle
		if (it.throttle < IDLE_THROTTLE) begin
			for (int m = 0; m < NUM_MOTORS; m++) drives[m] = MOTOR_W'(IDLE_DRIVE);
			return drives;
		end
		base = (longint'(IDLE_DRIVE) + longint'(it.throttle)) * FIX_ONE;
		drives[0] = drive_level(base + pitch_corr + roll_corr + yaw_corr);
		drives[1] = drive_level(base + pitch_corr - roll_corr - yaw_corr);
		drives[2] = drive_level(base - pitch_corr - roll_corr + yaw_corr);
		drives[3] = drive_level(base - pitch_corr + roll_corr - yaw_corr);
		return drives;
	endfunction

	function automatic logic [ERR_W-1:0] pick_error();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(0, 40)) - 20);
			2: return 16'(int'($urandom_range(0, 800)) - 400);
			3: return 16'(int'($urandom_range(0, 16000)) - 8000);
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'h7FFF;
					1: return 16'h8000;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
		endcase
	endfunction

	function automatic logic [THR_W-1:0] pick_throttle();
		case ($urandom_range(0, 5))
			0, 1, 2: return 11'($urandom_range(0, 2047));
			3: return 11'($urandom_range(95, 105));
			4: return 11'($urandom_range(0, 99));
			default: return ($urandom_range(0, 1) != 0) ? 11'd2047 : 11'd0;
		endcase
	endfunction

	function automatic logic [DT_W-1:0] pick_step_time();
		case ($urandom_range(0, 4))
			0, 1: return 16'($urandom_range(0, 65535));
			2: return 16'($urandom_range(0, 2000));
			3: return 16'd0;
			default: return 16'hFFFF;
		endcase
	endfunction

	task automatic send_item(input logic [ERR_W-1:0] yaw, input logic [ERR_W-1:0] pitch,
		input logic [ERR_W-1:0] roll, input logic [THR_W-1:0] thr, input logic [DT_W-1:0] dt);
		item_t it;
		it.yaw_error = yaw;
		it.pitch_error = pitch;
		it.roll_error = roll;
		it.throttle = thr;
		it.step_time = dt;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			// mostly short gaps, now and then one that spans a whole computation
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 500) : $urandom_range(1, 6))
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W - ITEM_W){1'b0}}, it};
		do @(posedge clk); while (!s_axis_tready);
		pending_drives.push_back(predict_drives(it));
	endtask

	task automatic drain_requests();
		s_axis_tvalid <= 1'b0;
		while (pending_drives.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_YAW_GAIN_P: gain_model.yaw.kp = value;
			REG_YAW_GAIN_I: gain_model.yaw.ki = value;
			REG_YAW_GAIN_D: gain_model.yaw.kd = value;
			REG_TILT_GAIN_P: gain_model.tilt.kp = value;
			REG_TILT_GAIN_I: gain_model.tilt.ki = value;
			REG_TILT_GAIN_D: gain_model.tilt.kd = value;
			default: ;
		endcase
	endtask

	task automatic load_gains(input logic [GAIN_W-1:0] yaw_p, input logic [GAIN_W-1:0] yaw_i,
		input logic [GAIN_W-1:0] yaw_d, input logic [GAIN_W-1:0] tilt_p,
		input logic [GAIN_W-1:0] tilt_i, input logic [GAIN_W-1:0] tilt_d);
		drain_requests();
		write_reg(REG_YAW_GAIN_P, yaw_p);
		write_reg(REG_YAW_GAIN_I, yaw_i);
		write_reg(REG_YAW_GAIN_D, yaw_d);
		write_reg(REG_TILT_GAIN_P, tilt_p);
		write_reg(REG_TILT_GAIN_I, tilt_i);
		write_reg(REG_TILT_GAIN_D, tilt_d);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random_items(input int count);
		repeat (count) send_item(pick_error(), pick_error(), pick_error(), pick_throttle(),
			pick_step_time());
		drain_requests();
	endtask

	// all gains still zero from reset
	task automatic test_reset_gains();
		send_item(16'h0000, 16'h0000, 16'h0000, 11'd2047, 16'h0000);
		send_item(16'h7FFF, 16'h8000, 16'h1234, 11'd99, 16'hFFFF);
		send_item(16'h0000, 16'h0000, 16'h0000, 11'd100, 16'h0001);
		drain_requests();
	endtask

	// writes to unused indexes, then loads all six gains and sends two requests
	task automatic test_register_writes();
		drain_requests();
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'hFFFF);
		load_gains(16'd120, 16'd40, 16'd250, 16'd180, 16'd25, 16'd90);
		send_item(16'h0010, 16'hFFF0, 16'h0008, 11'd900, 16'd1000);
		send_item(16'hFFE0, 16'h0020, 16'hFFF8, 11'd900, 16'd1000);
		drain_requests();
	endtask

	task automatic test_field_extremes();
		send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 11'd2047, 16'hFFFF);
		send_item(16'h8000, 16'h8000, 16'h8000, 11'd2047, 16'hFFFF);
		send_item(16'h7FFF, 16'h8000, 16'h7FFF, 11'd1024, 16'hFFFF);
		send_item(16'h0001, 16'hFFFF, 16'h0000, 11'd1024, 16'h0001);
		send_item(16'h0000, 16'h0000, 16'h0000, 11'd0, 16'h0000);
		drain_requests();
	endtask

	task automatic test_idle_throttle_low_mix();
		send_item(16'h7FFF, 16'h8000, 16'h7FFF, 11'd99, 16'hFFFF);
		// derivative sees the error taken while idling
		send_item(16'h0000, 16'h0000, 16'h0000, 11'd1500, 16'hFFFF);
		// large negative corrections drive sums below the idle level
		send_item(16'h8000, 16'h8000, 16'h8000, 11'd100, 16'hFFFF);
		send_item(16'h8000, 16'h7FFF, 16'h0000, 11'd100, 16'h8000);
		drain_requests();
	endtask

	task automatic test_zero_step_time();
		send_item(16'h0400, 16'hFC00, 16'h0200, 11'd1200, 16'h0000);
		send_item(16'h0400, 16'hFC00, 16'h0200, 11'd1200, 16'h0000);
		drain_requests();
	endtask

	task automatic test_small_gains();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		load_gains(GAIN_W'($urandom_range(0, 400)), GAIN_W'($urandom_range(0, 400)),
			GAIN_W'($urandom_range(0, 400)), GAIN_W'($urandom_range(0, 400)),
			GAIN_W'($urandom_range(0, 400)), GAIN_W'($urandom_range(0, 400)));
		run_random_items(135);
	endtask

	task automatic test_sender_gaps();
		sender_idle_pct = 78;
		receiver_stall_pct = 0;
		load_gains(GAIN_W'($urandom_range(0, 3000)), GAIN_W'($urandom_range(0, 3000)),
			GAIN_W'($urandom_range(0, 3000)), GAIN_W'($urandom_range(0, 3000)),
			GAIN_W'($urandom_range(0, 3000)), GAIN_W'($urandom_range(0, 3000)));
		run_random_items(135);
	endtask

	task automatic test_receiver_stalls();
		sender_idle_pct = 0;
		receiver_stall_pct = 78;
		load_gains(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
		run_random_items(135);
	endtask

	task automatic test_full_gain_range();
		sender_idle_pct = 26;
		receiver_stall_pct = 26;
		load_gains(GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 65535)),
			GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 65535)),
			GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 65535)));
		run_random_items(135);
	endtask

	// yaw and roll integrals run into the top limit, pitch into the bottom one
	task automatic test_integral_saturation();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		load_gains(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
		repeat (140) send_item(16'h7FFF, 16'h8000, 16'h7FFF, pick_throttle(), 16'hFFFF);
		repeat (5) send_item(16'h8000, 16'h7FFF, 16'h8000, pick_throttle(), 16'hFFFF);
		drain_requests();
	endtask

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < receiver_stall_pct) begin
			m_axis_tready <= 1'b0;
			// rare long stall so a finished result waits behind the pending one
			if ($urandom_range(0, 199) == 0) stall_hold <= $urandom_range(300, 900);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_drives
		drives_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_drives.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: expected no result, got %h", $time, m_axis_tdata);
			end else begin
				want = pending_drives.pop_front();
				for (int m = 0; m < NUM_MOTORS; m++) begin
					if (m_axis_tdata[m*MOTOR_W +: MOTOR_W] !== want[m]) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: %s expected %0d, got %0d", $time, motor_name[m],
								want[m], m_axis_tdata[m*MOTOR_W +: MOTOR_W]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_gains();
		test_register_writes();
		test_field_extremes();
		test_idle_throttle_low_mix();
		test_zero_step_time();
		test_small_gains();
		test_sender_gaps();
		test_receiver_stalls();
		test_full_gain_range();
		test_integral_saturation();

		drain_requests();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
